FILE: src/srsw_pkg.sv
`default_nettype none
package srsw_pkg;

    localparam int          WINDOW_SLOTS  = 16;

    localparam logic [31:0] ZERO_SEED_SUB = 32'h7061636b;
    localparam logic [31:0] HASH_K_SEQ    = 32'h9e3779b9;
    localparam logic [31:0] HASH_K_FRAME  = 32'h85ebca6b;
    localparam logic [31:0] HASH_K_MIX    = 32'h7feb352d;
    localparam int unsigned ACK_BITS      = 16;
    localparam logic [6:0]  ACK_HDR_BYTES = 7'd8;
    localparam logic [7:0]  ACK_KIND      = 8'd1;

    localparam logic [1:0] CFG_WINDOW = 2'd0;
    localparam logic [1:0] CFG_RETRY  = 2'd1;
    localparam logic [1:0] CFG_SEED   = 2'd2;
    localparam logic [1:0] CFG_MODE   = 2'd3;

    localparam logic FUNC_BUILD = 1'b0;
    localparam logic FUNC_ACK   = 1'b1;

    typedef struct packed {
        logic        func;
        logic [31:0] frame_no;
        logic [6:0]  offer_length;
        logic [6:0]  offer_payload;
        logic [7:0]  ack_kind;
        logic [7:0]  ack_mode;
        logic [6:0]  ack_frame_length;
        logic [31:0] ack_base;
        logic [15:0] ack_mask;
    } t_in_item;

    typedef struct packed {
        logic        data_sent;
        logic        is_retry;
        logic [31:0] sent_sequence;
        logic [3:0]  cell_slot;
        logic [6:0]  cell_bytes;
        logic        header_error;
        logic [10:0] acked_total_bytes;
        logic [10:0] acked_payload_bytes;
        logic [4:0]  cells_in_flight;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_H1,
        ST_SCAN_H2,
        ST_SCAN_MOD,
        ST_PICK_RD,
        ST_PICK,
        ST_OPEN,
        ST_ACK_RD,
        ST_ACK_WR,
        ST_DONE
    } t_state;

    function automatic logic [31:0] xorshift(input logic [31:0] s);
        logic [31:0] v;
        v = (s == 32'd0) ? ZERO_SEED_SUB : s;
        v = v ^ (v << 13);
        v = v ^ (v >> 17);
        v = v ^ (v << 5);
        return v;
    endfunction

endpackage
`default_nettype wire

FILE: src/srsw_if.sv
`default_nettype none
interface srsw_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: src/srsw_ram.sv
`default_nettype none
module srsw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]         i_wdata,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: src/srsw_mod.sv
`default_nettype none
// Sequential remainder a % d, one quotient bit per cycle.
module srsw_mod (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_start,
    input  wire  [31:0] i_num,
    input  wire  [31:0] i_den,
    output logic        o_done,
    output logic [31:0] o_rem
);
    logic [31:0] r_num, n_num, r_den;
    logic [32:0] r_rem, n_rem, w_sh;
    logic [5:0]  r_cnt;
    logic        r_busy;

    always_comb begin
        w_sh  = {r_rem[31:0], r_num[31]};
        n_rem = (w_sh >= {1'b0, r_den}) ? w_sh - {1'b0, r_den} : w_sh;
        n_num = {r_num[30:0], 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd32;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= n_num;
            r_rem <= n_rem;
        end
    end

    assign o_rem = r_rem[31:0];
endmodule
`default_nettype wire

FILE: src/selective_repeat_sender_window.sv
`default_nettype none
// Selective-repeat ARQ sender window. One item in, one result out per item; the
// next item is taken only after the result has been accepted. Cell state sits in
// one RAM (one word per slot) with a registered read. A build item scans all
// slots: per slot a RAM read, two hash stages and a serial remainder. With
// nothing to resend, an attempt to open a cell and finishing follow the scan.
// When a resend is chosen, a remainder draw and a pick pass over the slots up to
// the chosen one follow instead. An ack item takes a read and a write state per
// slot; a rejected ack goes straight to the result. Configuration writes must
// only be issued while no item is in flight.
module selective_repeat_sender_window #(
    parameter int SLOT_BYTES   = 83
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [31:0] i_cfg_data,
    srsw_if.sink        i_in,
    srsw_if.source      o_out
);
    import srsw_pkg::*;

    localparam int SW = $clog2(WINDOW_SLOTS);
    localparam int CW = $clog2(WINDOW_SLOTS + 1);
    localparam int MW = 1 + 32 + 32 + 7 + 7;

    typedef struct packed {
        logic        valid;
        logic [31:0] seq;
        logic [31:0] sent;
        logic [6:0]  tot;
        logic [6:0]  pay;
    } t_cell;

    t_state r_state, n_state;
    logic [4:0]  r_win;
    logic [15:0] r_retry;
    logic [7:0]  r_mode;
    logic [31:0] r_rng, r_next_seq, r_peer_base;
    logic [WINDOW_SLOTS-1:0] r_vld;
    logic [WINDOW_SLOTS-1:0] r_elig;
    t_in_item  r_in;
    t_out_item r_out;
    logic      r_out_v;
    logic [SW:0] r_idx;
    logic [CW-1:0] r_cnt;
    logic [31:0] r_pick;
    logic [31:0] r_h, r_age;
    logic [12:0] r_sum_t, r_sum_p;
    t_cell r_cell;
    logic  r_pick_go;

    logic         w_we;
    logic [SW-1:0] w_waddr, w_raddr;
    t_cell        w_wdata, w_rdata;
    logic         w_mstart, w_mdone;
    logic [31:0]  w_mnum, w_mden, w_mrem;
    logic [31:0]  w_spread, w_hx, w_hm;
    logic [CW-1:0] w_flight;
    logic [SW-1:0] w_slot;
    logic [6:0]   w_len;
    logic [31:0]  w_delay;
    logic         w_rel;
    logic [32:0]  w_ackoff;
    logic         w_ack_bad;
    logic         w_open_ok;
    t_out_item    w_out_init;

    srsw_ram #(.WIDTH(MW), .DEPTH(WINDOW_SLOTS)) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    srsw_mod u_mod (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_mstart),
        .i_num  (w_mnum),
        .i_den  (w_mden),
        .o_done (w_mdone),
        .o_rem  (w_mrem)
    );

    assign i_in.ready = (r_state == ST_IDLE) && !r_out_v;
    assign o_out.valid = r_out_v;
    assign o_out.data  = r_out;

    always_comb begin
        w_flight = '0;
        for (int i = 0; i < WINDOW_SLOTS; i++) begin
            w_flight = w_flight + CW'(r_vld[i]);
        end
    end

    assign w_ack_bad = (i_in.data.func == FUNC_ACK) &&
                       (i_in.data.ack_frame_length < ACK_HDR_BYTES ||
                        i_in.data.ack_kind != ACK_KIND ||
                        i_in.data.ack_mode != r_mode ||
                        i_in.data.ack_base > r_next_seq);

    always_comb begin
        w_out_init               = '0;
        w_out_init.sent_sequence = '1;
        w_out_init.header_error  = w_ack_bad;
    end

    assign w_spread = (r_retry < 16'd4) ? 32'd4 : {16'd0, r_retry};
    assign w_hx     = r_rng ^ (r_cell.seq * HASH_K_SEQ) ^ (r_cell.sent * HASH_K_FRAME);
    assign w_hm     = r_h * HASH_K_MIX;
    assign w_delay  = {16'd0, r_retry} + w_mrem;
    assign w_slot   = r_next_seq[SW-1:0];
    assign w_len    = (32'(r_in.offer_length) > SLOT_BYTES) ? 7'(SLOT_BYTES)
                                                            : r_in.offer_length;
    assign w_ackoff = {1'b0, w_rdata.seq} - {1'b0, r_in.ack_base};
    assign w_rel    = w_rdata.valid && r_vld[r_idx[SW-1:0]] &&
                      ((w_rdata.seq < r_in.ack_base) ||
                       ((w_rdata.seq < r_next_seq) && (w_ackoff < 33'(ACK_BITS)) &&
                        r_in.ack_mask[w_ackoff[3:0]]));
    assign w_open_ok = r_in.offer_length != '0 &&
                       5'(w_flight) < ((r_win > 5'(WINDOW_SLOTS)) ? 5'(WINDOW_SLOTS)
                                                                 : r_win) &&
                       {1'b0, r_next_seq} < {1'b0, r_peer_base} + 33'(ACK_BITS) &&
                       r_next_seq != '1 && !r_vld[w_slot];

    assign w_mstart = (r_state == ST_SCAN_H2) || r_pick_go;
    assign w_mnum   = (r_state == ST_SCAN_H2) ? (w_hm ^ (w_hm >> 15)) : r_pick;
    assign w_mden   = (r_state == ST_SCAN_H2) ? w_spread : 32'(r_cnt);

    always_comb begin
        w_raddr = r_idx[SW-1:0];
        w_we    = 1'b0;
        w_waddr = r_idx[SW-1:0];
        w_wdata = r_cell;
        unique case (r_state)
            ST_IDLE:     w_raddr = '0;
            ST_SCAN_MOD: w_raddr = r_idx[SW-1:0] + SW'(1);
            ST_PICK: begin
                w_raddr = r_idx[SW-1:0] + SW'(1);
                w_we = r_elig[r_idx[SW-1:0]] && (r_pick == 32'd0);
                w_wdata = w_rdata;
                w_wdata.sent = r_in.frame_no;
            end
            ST_OPEN: begin
                w_we = w_open_ok;
                w_waddr = w_slot;
                w_wdata.valid = 1'b1;
                w_wdata.seq   = r_next_seq;
                w_wdata.sent  = r_in.frame_no;
                w_wdata.tot   = w_len;
                w_wdata.pay   = (r_in.offer_payload > w_len) ? w_len : r_in.offer_payload;
            end
            ST_ACK_WR: begin
                w_we = w_rel;
                w_wdata = '0;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in.valid && i_in.ready) begin
                    n_state = (i_in.data.func == FUNC_ACK) ? ST_ACK_RD : ST_SCAN_RD;
                end
            end
            ST_SCAN_RD: begin
                if (r_idx[SW]) begin
                    n_state = (r_cnt != '0) ? ST_PICK_RD : ST_OPEN;
                end else begin
                    n_state = ST_SCAN_H1;
                end
            end
            ST_SCAN_H1:  n_state = ST_SCAN_H2;
            ST_SCAN_H2:  n_state = ST_SCAN_MOD;
            ST_SCAN_MOD: if (w_mdone) n_state = ST_SCAN_RD;
            ST_PICK_RD:  if (w_mdone) n_state = ST_PICK;
            ST_PICK: begin
                if (w_we || r_idx == (SW+1)'(WINDOW_SLOTS - 1)) n_state = ST_DONE;
            end
            ST_OPEN:     n_state = ST_DONE;
            ST_ACK_RD:   n_state = r_idx[SW] ? ST_DONE : ST_ACK_WR;
            ST_ACK_WR:   n_state = ST_ACK_RD;
            ST_DONE:     n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_win       <= 5'd16;
            r_retry     <= 16'd8;
            r_mode      <= '0;
            r_rng       <= '0;
            r_next_seq  <= '0;
            r_peer_base <= '0;
            r_vld       <= '0;
            r_out_v     <= 1'b0;
            r_pick_go   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pick_go <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_WINDOW: r_win   <= i_cfg_data[4:0];
                    CFG_RETRY:  r_retry <= i_cfg_data[15:0];
                    CFG_SEED:   r_rng   <= i_cfg_data;
                    CFG_MODE:   r_mode  <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (o_out.valid && o_out.ready) begin
                r_out_v <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in.valid && i_in.ready) begin
                        r_in    <= i_in.data;
                        r_idx   <= w_ack_bad ? (SW+1)'(WINDOW_SLOTS) : '0;
                        r_cnt   <= '0;
                        r_elig  <= '0;
                        r_sum_t <= '0;
                        r_sum_p <= '0;
                        r_out   <= w_out_init;
                        if (i_in.data.func == FUNC_ACK && !w_ack_bad &&
                            i_in.data.ack_base > r_peer_base) begin
                            r_peer_base <= i_in.data.ack_base;
                        end
                    end
                end
                ST_SCAN_RD: begin
                    if (r_idx[SW]) begin
                        if (r_cnt != '0) begin
                            r_pick <= xorshift(r_rng);
                            r_rng  <= xorshift(r_rng);
                            r_pick_go <= 1'b1;
                            r_idx <= '0;
                        end
                    end else begin
                        r_cell <= w_rdata;
                    end
                end
                ST_SCAN_H1: r_h <= w_hx ^ (w_hx >> 16);
                ST_SCAN_H2: begin
                    r_h   <= w_hm;
                    r_age <= r_in.frame_no - r_cell.sent;
                end
                ST_SCAN_MOD: begin
                    if (w_mdone) begin
                        if (r_vld[r_idx[SW-1:0]] && r_age >= w_delay) begin
                            r_elig[r_idx[SW-1:0]] <= 1'b1;
                            r_cnt <= r_cnt + CW'(1);
                        end
                        r_idx <= r_idx + 1'b1;
                    end
                end
                ST_PICK_RD: begin
                    if (w_mdone) r_pick <= w_mrem;
                end
                ST_PICK: begin
                    if (w_we) begin
                        r_out.data_sent     <= 1'b1;
                        r_out.is_retry      <= 1'b1;
                        r_out.sent_sequence <= w_rdata.seq;
                        r_out.cell_slot     <= 4'(r_idx[SW-1:0]);
                        r_out.cell_bytes    <= w_rdata.tot;
                    end else begin
                        if (r_elig[r_idx[SW-1:0]]) r_pick <= r_pick - 32'd1;
                        r_idx <= r_idx + 1'b1;
                    end
                end
                ST_OPEN: begin
                    if (w_open_ok) begin
                        r_vld[w_slot]       <= 1'b1;
                        r_next_seq          <= r_next_seq + 32'd1;
                        r_out.data_sent     <= 1'b1;
                        r_out.sent_sequence <= r_next_seq;
                        r_out.cell_slot     <= 4'(w_slot);
                        r_out.cell_bytes    <= w_len;
                    end
                end
                ST_ACK_WR: begin
                    if (w_rel) begin
                        r_vld[r_idx[SW-1:0]] <= 1'b0;
                        r_sum_t <= r_sum_t + 13'(w_rdata.tot);
                        r_sum_p <= r_sum_p + 13'(w_rdata.pay);
                    end
                    r_idx <= r_idx + 1'b1;
                end
                ST_DONE: begin
                    r_out_v <= 1'b1;
                    r_out.acked_total_bytes   <= (r_sum_t > 13'd2047) ? 11'd2047 : r_sum_t[10:0];
                    r_out.acked_payload_bytes <= (r_sum_p > 13'd2047) ? 11'd2047 : r_sum_p[10:0];
                    r_out.cells_in_flight     <= 5'(w_flight);
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire
